/* src/irrs_pkg.sv */
// Shared constants and types of the input record ring with statistics.
// Used by the channel interfaces, the counter bank and the top level.
package irrs_pkg;

  localparam int unsigned RING_DEPTH_DEF = 256;
  localparam int unsigned MAX_RUN_DEF    = 64;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned FLAG_W  = 4;
  localparam int unsigned PAY_W   = 64;
  localparam int unsigned POS_W   = 64;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned SEL_W   = 3;
  localparam int unsigned STAT_W  = 64;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned NUM_CNT = 8;

  localparam logic [CFG_W-1:0] CAP_LOG2_RST = 4'd8;

  localparam logic [OP_W-1:0] OP_PUBLISH  = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAIN    = 2'd1;
  localparam logic [OP_W-1:0] OP_SNAPSHOT = 2'd2;
  localparam logic [OP_W-1:0] OP_STAT     = 2'd3;

  localparam int unsigned CNT_PUBLISHED = 0;
  localparam int unsigned CNT_MOTION    = 1;
  localparam int unsigned CNT_DROPPED   = 5;
  localparam int unsigned CNT_DRAINS    = 6;
  localparam int unsigned CNT_CONSUMED  = 7;

  typedef struct packed {
    logic               start;
    logic [NUM_CNT-1:0] mask;
    logic [CNT_W-1:0]   amount;
    logic               query;
    logic [SEL_W-1:0]   index;
  } stat_cmd_t;

endpackage

/* src/irrs_req_if.sv */
// Request channel of the record ring: one beat per operation.
// Depends on irrs_pkg for the field widths.
interface irrs_req_if import irrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [FLAG_W-1:0] record_flags;
  logic [PAY_W-1:0]  record_payload;
  logic [CNT_W-1:0]  max_count;
  logic [POS_W-1:0]  read_cursor;
  logic [SEL_W-1:0]  stat_index;

  modport source (
    output valid, operation, record_flags, record_payload, max_count, read_cursor,
           stat_index,
    input  ready
  );
  modport sink (
    input  valid, operation, record_flags, record_payload, max_count, read_cursor,
           stat_index,
    output ready
  );
endinterface

/* src/irrs_rsp_if.sv */
// Result channel of the record ring: one beat per result.
// Depends on irrs_pkg for the field widths.
interface irrs_rsp_if import irrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FLAG_W-1:0] out_flags;
  logic [PAY_W-1:0]  out_payload;
  logic              has_record;
  logic              last;
  logic              accepted;
  logic              status;
  logic [CNT_W-1:0]  returned_count;
  logic [POS_W-1:0]  new_cursor;
  logic [STAT_W-1:0] stat_value;

  modport source (
    output valid, out_flags, out_payload, has_record, last, accepted, status,
           returned_count, new_cursor, stat_value,
    input  ready
  );
  modport sink (
    input  valid, out_flags, out_payload, has_record, last, accepted, status,
           returned_count, new_cursor, stat_value,
    output ready
  );
endinterface

/* src/irrs_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module irrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/irrs_stats.sv */
// Bank of eight wrapping 64-bit event counters kept in a RAM, updated by
// read-modify-write one counter at a time. Depends on irrs_pkg and irrs_ram.
module irrs_stats import irrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stat_cmd_t         cmd_i,
  output logic              busy_o,
  output logic [STAT_W-1:0] value_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [1:0]         st_q, st_d;
  logic [NUM_CNT-1:0] mask_q, mask_d;
  logic [CNT_W-1:0]   amt_q, amt_d;
  logic [SEL_W-1:0]   idx_q, idx_d;
  logic [NUM_CNT-1:0] vld_q, vld_d;
  logic               qv_q, qv_d;
  logic [SEL_W-1:0]   low_idx;
  logic               re;
  logic [SEL_W-1:0]   raddr;
  logic               we;
  logic [STAT_W-1:0]  wdata;
  logic [STAT_W-1:0]  rdata;
  logic [STAT_W-1:0]  old_val;

  always_comb begin
    low_idx = '0;
    for (int i = NUM_CNT - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        low_idx = SEL_W'(i);
      end
    end
  end

  assign old_val = vld_q[idx_q] ? rdata : '0;

  always_comb begin
    st_d   = st_q;
    mask_d = mask_q;
    amt_d  = amt_q;
    idx_d  = idx_q;
    vld_d  = vld_q;
    qv_d   = qv_q;
    re     = 1'b0;
    raddr  = low_idx;
    we     = 1'b0;
    wdata  = old_val + ((idx_q == SEL_W'(CNT_CONSUMED)) ? STAT_W'(amt_q) : STAT_W'(1));
    case (st_q)
      ST_IDLE: begin
        if (cmd_i.query) begin
          re    = 1'b1;
          raddr = cmd_i.index;
          qv_d  = vld_q[cmd_i.index];
        end
        if (cmd_i.start && (cmd_i.mask != '0)) begin
          mask_d = cmd_i.mask;
          amt_d  = cmd_i.amount;
          st_d   = ST_RD;
        end
      end
      ST_RD: begin
        re    = 1'b1;
        idx_d = low_idx;
        st_d  = ST_WR;
      end
      ST_WR: begin
        we             = 1'b1;
        vld_d[idx_q]   = 1'b1;
        mask_d[idx_q]  = 1'b0;
        st_d           = (mask_d != '0) ? ST_RD : ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      mask_q <= '0;
      vld_q  <= '0;
      qv_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      mask_q <= mask_d;
      vld_q  <= vld_d;
      qv_q   <= qv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amt_q <= amt_d;
    idx_q <= idx_d;
  end

  irrs_ram #(
    .WIDTH (STAT_W),
    .DEPTH (NUM_CNT)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy_o  = (st_q != ST_IDLE);
  assign value_o = qv_q ? rdata : '0;

endmodule

/* src/input_record_ring_with_stats_unit.sv */
// Top level of the input record ring with statistics.
// Depends on irrs_pkg, irrs_req_if, irrs_rsp_if, irrs_ram and irrs_stats.
//
// Records are kept in one RAM of RING_DEPTH entries of flags and payload; the
// event counters live in a second eight-entry RAM that is updated one counter
// at a time by read-modify-write. A request beat is registered when it is
// taken and evaluated in S_EVAL once the result register is free. A publish
// bumps one counter when the record is dropped and up to five when it is
// stored, and the next beat is taken once the counter updates are done. A
// stat query reads the counter RAM in S_EVAL and returns its value from S_STAT. A
// drain or snapshot reads one record at a time through the registered read of
// the record RAM and issues a read only once the previous record is in the
// result register; a drain that returns records also bumps two counters. An
// empty drain, empty snapshot or cursor overflow gives one result beat with
// no record read. A stalled result beat holds all of these back. The result
// register lets a new request beat in while the last result still waits.
module input_record_ring_with_stats_unit import irrs_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned MAX_RUN    = MAX_RUN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  irrs_req_if.sink         req_i,
  irrs_rsp_if.source       rsp_o
);

  localparam int unsigned AW         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned DEPTH_LOG2 = $clog2(RING_DEPTH + 1) - 1;
  localparam int unsigned CAP_W      = DEPTH_LOG2 + 1;
  localparam int unsigned REC_W      = FLAG_W + PAY_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_STAT = 2'd3;

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [PAY_W-1:0]  payload;
    logic              has_record;
    logic              last;
    logic              accepted;
    logic              status;
    logic [CNT_W-1:0]  count;
    logic [POS_W-1:0]  cursor;
    logic [STAT_W-1:0] stat;
  } rsp_t;

  logic [CFG_W-1:0]  cap_log2_q;
  logic [1:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q;
  logic [FLAG_W-1:0] flags_q;
  logic [PAY_W-1:0]  payload_q;
  logic [CNT_W-1:0]  limit_q, limit_in;
  logic [POS_W-1:0]  cursor_q;
  logic [SEL_W-1:0]  sel_q;
  logic [POS_W-1:0]  diff_q;
  logic              ahead_q;
  logic [POS_W-1:0]  wp_q, wp_d;
  logic [POS_W-1:0]  rp_q, rp_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [POS_W-1:0]  ncur_q, ncur_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;
  logic              out_v_q, out_v_d;
  rsp_t              out_q, out_d;

  logic [CFG_W-1:0]  eff_log2;
  logic [CAP_W-1:0]  cap;
  logic [CAP_W-1:0]  cap_m1;
  logic [AW-1:0]     addr_mask;
  logic [POS_W-1:0]  cap64;
  logic              req_fire;
  logic              out_free;
  logic [CNT_W-1:0]  n_calc;
  logic              ram_we;
  logic              ram_re;
  logic [REC_W-1:0]  ram_rdata;
  stat_cmd_t         stat_cmd;
  logic              stat_busy;
  logic [STAT_W-1:0] stat_value;

  assign eff_log2  = (32'(cap_log2_q) > DEPTH_LOG2) ? CFG_W'(DEPTH_LOG2) : cap_log2_q;
  assign cap       = CAP_W'(1) << eff_log2;
  assign cap_m1    = cap - CAP_W'(1);
  assign addr_mask = cap_m1[AW-1:0];
  assign cap64     = POS_W'(cap);

  assign req_i.ready = (state_q == S_IDLE) && !stat_busy;
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_v_q || rsp_o.ready;
  assign limit_in    = (32'(req_i.max_count) > MAX_RUN) ? CNT_W'(MAX_RUN) : req_i.max_count;
  assign n_calc      = (diff_q > POS_W'(limit_q)) ? limit_q : diff_q[CNT_W-1:0];

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    n_d         = n_q;
    left_d      = left_q;
    ptr_d       = ptr_q;
    ncur_d      = ncur_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    out_v_d     = out_v_q && !rsp_o.ready;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    stat_cmd    = '0;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          out_d      = '0;
          out_d.last = 1'b1;
          state_d    = S_IDLE;
          case (op_q)
            OP_PUBLISH: begin
              out_v_d = 1'b1;
              if (diff_q >= cap64) begin
                stat_cmd.start              = 1'b1;
                stat_cmd.mask[CNT_DROPPED]  = 1'b1;
              end else begin
                ram_we                             = 1'b1;
                wp_d                               = wp_q + POS_W'(1);
                stat_cmd.start                     = 1'b1;
                stat_cmd.mask[CNT_PUBLISHED]       = 1'b1;
                stat_cmd.mask[CNT_MOTION +: FLAG_W] = flags_q;
                out_d.accepted                     = 1'b1;
              end
            end
            OP_DRAIN: begin
              if (n_calc == '0) begin
                out_v_d = 1'b1;
              end else begin
                rp_d                        = rp_q + POS_W'(n_calc);
                stat_cmd.start              = 1'b1;
                stat_cmd.mask[CNT_DRAINS]   = 1'b1;
                stat_cmd.mask[CNT_CONSUMED] = 1'b1;
                stat_cmd.amount             = n_calc;
                n_d                         = n_calc;
                left_d                      = n_calc;
                ptr_d                       = rp_q[AW-1:0];
                ncur_d                      = '0;
                state_d                     = S_RUN;
              end
            end
            OP_SNAPSHOT: begin
              if (ahead_q || (diff_q > cap64)) begin
                out_v_d      = 1'b1;
                out_d.status = 1'b1;
                out_d.cursor = cursor_q;
              end else if (n_calc == '0) begin
                out_v_d      = 1'b1;
                out_d.cursor = cursor_q;
              end else begin
                n_d     = n_calc;
                left_d  = n_calc;
                ptr_d   = cursor_q[AW-1:0];
                ncur_d  = cursor_q + POS_W'(n_calc);
                state_d = S_RUN;
              end
            end
            OP_STAT: begin
              stat_cmd.query = 1'b1;
              stat_cmd.index = sel_q;
              state_d        = S_STAT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RUN: begin
        if (pend_q) begin
          out_v_d          = 1'b1;
          out_d            = '0;
          out_d.flags      = ram_rdata[REC_W-1 -: FLAG_W];
          out_d.payload    = ram_rdata[PAY_W-1:0];
          out_d.has_record = 1'b1;
          out_d.last       = pend_last_q;
          out_d.count      = n_q;
          out_d.cursor     = ncur_q;
          if (pend_last_q) begin
            state_d = S_IDLE;
          end
        end else if ((left_q != '0) && out_free) begin
          ram_re      = 1'b1;
          pend_d      = 1'b1;
          pend_last_d = (left_q == CNT_W'(1));
          left_d      = left_q - CNT_W'(1);
          ptr_d       = ptr_q + AW'(1);
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_d      = '0;
          out_d.last = 1'b1;
          out_d.stat = stat_value;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_log2_q <= CAP_LOG2_RST;
      state_q    <= S_IDLE;
      wp_q       <= '0;
      rp_q       <= '0;
      left_q     <= '0;
      pend_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_log2_q <= cfg_data_i;
      end
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q      <= req_i.operation;
      flags_q   <= req_i.record_flags;
      payload_q <= req_i.record_payload;
      limit_q   <= limit_in;
      cursor_q  <= req_i.read_cursor;
      sel_q     <= req_i.stat_index;
      diff_q    <= wp_q - ((req_i.operation == OP_SNAPSHOT) ? req_i.read_cursor : rp_q);
      ahead_q   <= (req_i.read_cursor > wp_q);
    end
    n_q         <= n_d;
    ptr_q       <= ptr_d;
    ncur_q      <= ncur_d;
    pend_last_q <= pend_last_d;
    out_q       <= out_d;
  end

  irrs_ram #(
    .WIDTH (REC_W),
    .DEPTH (RING_DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q[AW-1:0] & addr_mask),
    .wdata_i ({flags_q, payload_q}),
    .re_i    (ram_re),
    .raddr_i (ptr_q & addr_mask),
    .rdata_o (ram_rdata)
  );

  irrs_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (stat_cmd),
    .busy_o  (stat_busy),
    .value_o (stat_value)
  );

  assign rsp_o.valid          = out_v_q;
  assign rsp_o.out_flags      = out_q.flags;
  assign rsp_o.out_payload    = out_q.payload;
  assign rsp_o.has_record     = out_q.has_record;
  assign rsp_o.last           = out_q.last;
  assign rsp_o.accepted       = out_q.accepted;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.returned_count = out_q.count;
  assign rsp_o.new_cursor     = out_q.cursor;
  assign rsp_o.stat_value     = out_q.stat;

endmodule

/* sim/input_record_ring_with_stats_unit_test.sv */
// Testbench of input_record_ring_with_stats_unit: publish, drain, snapshot and stat beats
// checked against an in-bench ring model. Depends on irrs_pkg, irrs_req_if and irrs_rsp_if.
// Runs directed cases, then random phases over several capacities with bursty traffic.
module input_record_ring_with_stats_unit_test;
  import irrs_pkg::*;

  localparam int unsigned RESET_CYCLES  = 4;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned PHASE_ITEMS   = 32;
  localparam int unsigned FILL_ITEMS    = 70;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [FLAG_W-1:0] record_flags;
    logic [PAY_W-1:0]  record_payload;
    logic [CNT_W-1:0]  max_count;
    logic [POS_W-1:0]  read_cursor;
    logic [SEL_W-1:0]  stat_index;
  } ring_op_t;

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [PAY_W-1:0]  payload;
    logic              has_rec;
    logic              is_last;
    logic              stored;
    logic              overflow;
    logic [CNT_W-1:0]  count;
    logic [POS_W-1:0]  cursor;
    logic [STAT_W-1:0] stat;
  } ring_result_t;

  typedef enum logic [1:0] {RX_FULL, RX_HALF, RX_MOST, RX_SPARSE} rx_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  irrs_req_if req_if ();
  irrs_rsp_if rsp_if ();

  input_record_ring_with_stats_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  ring_op_t     ops_to_send[$];
  ring_result_t ring_results_due[$];
  int unsigned  fail_count = 0;
  logic         hold_arm = 1'b0;

  logic [PAY_W-1:0]  payload_mem [RING_DEPTH_DEF];
  logic [FLAG_W-1:0] flag_mem [RING_DEPTH_DEF];
  logic              entry_written [RING_DEPTH_DEF];
  logic [POS_W-1:0]  wr_pos;
  logic [POS_W-1:0]  rd_pos;
  logic [STAT_W-1:0] event_ctr [NUM_CNT];
  logic [CFG_W-1:0]  cap_log2;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.operation = '0;
    req_if.record_flags = '0;
    req_if.record_payload = '0;
    req_if.max_count = '0;
    req_if.read_cursor = '0;
    req_if.stat_index = '0;
    rsp_if.ready = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [POS_W-1:0] ring_cap();
    logic [POS_W-1:0] c;
    c = 64'd1 << cap_log2;
    while (c > RING_DEPTH_DEF) c = c >> 1;
    return c;
  endfunction

  function automatic ring_op_t make_op(logic [OP_W-1:0] opc, logic [FLAG_W-1:0] flags,
                                       logic [PAY_W-1:0] payload, logic [CNT_W-1:0] maxc,
                                       logic [POS_W-1:0] cursor, logic [SEL_W-1:0] sel);
    ring_op_t op;
    op.operation = opc;
    op.record_flags = flags;
    op.record_payload = payload;
    op.max_count = maxc;
    op.read_cursor = cursor;
    op.stat_index = sel;
    return op;
  endfunction

  task automatic emit_records(logic [POS_W-1:0] start, logic [POS_W-1:0] n,
                              logic [POS_W-1:0] cursor_out);
    ring_result_t r;
    logic [POS_W-1:0] idx;
    r = '0;
    r.cursor = cursor_out;
    if (n == 0) begin
      r.is_last = 1'b1;
      ring_results_due.push_back(r);
    end else begin
      for (logic [POS_W-1:0] i = 0; i < n; i++) begin
        idx = (start + i) & (ring_cap() - 1);
        r.flags = flag_mem[idx];
        r.payload = payload_mem[idx];
        r.has_rec = 1'b1;
        r.is_last = (i + 1 == n);
        r.count = n[CNT_W-1:0];
        ring_results_due.push_back(r);
      end
    end
  endtask

  task automatic ring_apply(ring_op_t op);
    ring_result_t r;
    logic [POS_W-1:0] cap;
    logic [POS_W-1:0] lim;
    logic [POS_W-1:0] n;
    cap = ring_cap();
    lim = (op.max_count > MAX_RUN_DEF) ? POS_W'(MAX_RUN_DEF) : POS_W'(op.max_count);
    r = '0;
    r.is_last = 1'b1;
    case (op.operation)
      OP_PUBLISH: begin
        if (wr_pos - rd_pos >= cap) begin
          event_ctr[CNT_DROPPED]++;
        end else begin
          payload_mem[wr_pos & (cap - 1)] = op.record_payload;
          flag_mem[wr_pos & (cap - 1)] = op.record_flags;
          entry_written[wr_pos & (cap - 1)] = 1'b1;
          wr_pos++;
          event_ctr[CNT_PUBLISHED]++;
          for (int b = 0; b < FLAG_W; b++)
            if (op.record_flags[b]) event_ctr[CNT_MOTION + b]++;
          r.stored = 1'b1;
        end
        ring_results_due.push_back(r);
      end
      OP_DRAIN: begin
        n = wr_pos - rd_pos;
        if (n > lim) n = lim;
        emit_records(rd_pos, n, '0);
        if (n != 0) begin
          rd_pos += n;
          event_ctr[CNT_DRAINS]++;
          event_ctr[CNT_CONSUMED] += n;
        end
      end
      OP_SNAPSHOT: begin
        if (op.read_cursor > wr_pos || wr_pos - op.read_cursor > cap) begin
          r.overflow = 1'b1;
          r.cursor = op.read_cursor;
          ring_results_due.push_back(r);
        end else begin
          n = wr_pos - op.read_cursor;
          if (n > lim) n = lim;
          emit_records(op.read_cursor, n, op.read_cursor + n);
        end
      end
      default: begin
        r.stat = event_ctr[op.stat_index];
        ring_results_due.push_back(r);
      end
    endcase
  endtask

  // Shorten a drain or snapshot so that it stops before an entry never written.
  function automatic ring_op_t clip_to_written(ring_op_t op);
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] avail;
    logic [POS_W-1:0] lim;
    logic [POS_W-1:0] k;
    logic [POS_W-1:0] cap;
    cap = ring_cap();
    if (op.operation == OP_DRAIN) begin
      base = rd_pos;
      avail = wr_pos - rd_pos;
    end else if (op.operation == OP_SNAPSHOT && op.read_cursor <= wr_pos &&
                 wr_pos - op.read_cursor <= cap) begin
      base = op.read_cursor;
      avail = wr_pos - op.read_cursor;
    end else begin
      return op;
    end
    lim = (op.max_count > MAX_RUN_DEF) ? POS_W'(MAX_RUN_DEF) : POS_W'(op.max_count);
    if (avail < lim) lim = avail;
    for (k = 0; k < lim && entry_written[(base + k) & (cap - 1)]; k++);
    if (k < lim) op.max_count = k[CNT_W-1:0];
    return op;
  endfunction

  task automatic queue_op(ring_op_t op);
    ring_op_t clipped;
    clipped = clip_to_written(op);
    ring_apply(clipped);
    ops_to_send.push_back(clipped);
  endtask

  function automatic ring_op_t random_op(int unsigned pub_pct);
    ring_op_t op;
    int unsigned roll;
    int unsigned rest;
    logic [POS_W-1:0] cap;
    cap = ring_cap();
    roll = $urandom_range(0, 99);
    rest = 100 - pub_pct;
    if (roll < pub_pct) op.operation = OP_PUBLISH;
    else if (roll < pub_pct + rest * 2 / 5) op.operation = OP_DRAIN;
    else if (roll < pub_pct + rest * 4 / 5) op.operation = OP_SNAPSHOT;
    else op.operation = OP_STAT;
    op.record_flags = FLAG_W'($urandom);
    op.record_payload = {$urandom, $urandom};
    op.max_count = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 127)) :
                                                 CNT_W'($urandom_range(0, 12));
    op.stat_index = SEL_W'($urandom);
    case ($urandom_range(0, 9))
      0: op.read_cursor = {$urandom, $urandom};
      1: op.read_cursor = wr_pos + $urandom_range(1, 4);
      2: op.read_cursor = wr_pos - cap - $urandom_range(1, 4);
      default: op.read_cursor = wr_pos - $urandom_range(0, int'(cap));
    endcase
    return op;
  endfunction

  task automatic wait_drained();
    while (ops_to_send.size() != 0 || ring_results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cap(logic [CFG_W-1:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cap_log2 = value;
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    ring_op_t cur;
    int unsigned burst_left;
    int unsigned gap_left;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.operation <= '0;
      req_if.record_flags <= '0;
      req_if.record_payload <= '0;
      req_if.max_count <= '0;
      req_if.read_cursor <= '0;
      req_if.stat_index <= '0;
      burst_left = 0;
      gap_left = 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (gap_left != 0 || ops_to_send.size() == 0) begin
        req_if.valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        cur = ops_to_send.pop_front();
        req_if.valid <= 1'b1;
        req_if.operation <= cur.operation;
        req_if.record_flags <= cur.record_flags;
        req_if.record_payload <= cur.record_payload;
        req_if.max_count <= cur.max_count;
        req_if.read_cursor <= cur.read_cursor;
        req_if.stat_index <= cur.stat_index;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_receiver
    rx_mode_e mode;
    int unsigned mode_left;
    int unsigned hold_left;
    logic hold_done;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      mode = RX_FULL;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_arm && !hold_done) begin
        rsp_if.ready <= 1'b0;
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end else begin
        case (mode)
          RX_FULL:   rsp_if.ready <= 1'b1;
          RX_HALF:   rsp_if.ready <= ($urandom_range(0, 1) != 0);
          RX_MOST:   rsp_if.ready <= ($urandom_range(0, 4) != 0);
          default:   rsp_if.ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    ring_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (ring_results_due.size() == 0) begin
        $display("%0t: result beat with none expected, actual payload %h stat %h",
                 $time, rsp_if.out_payload, rsp_if.stat_value);
        fail_count++;
      end else begin
        want = ring_results_due.pop_front();
        check_field("out_flags", 64'(want.flags), 64'(rsp_if.out_flags));
        check_field("out_payload", want.payload, rsp_if.out_payload);
        check_field("has_record", 64'(want.has_rec), 64'(rsp_if.has_record));
        check_field("last", 64'(want.is_last), 64'(rsp_if.last));
        check_field("accepted", 64'(want.stored), 64'(rsp_if.accepted));
        check_field("status", 64'(want.overflow), 64'(rsp_if.status));
        check_field("returned_count", 64'(want.count), 64'(rsp_if.returned_count));
        check_field("new_cursor", want.cursor, rsp_if.new_cursor);
        check_field("stat_value", want.stat, rsp_if.stat_value);
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] phase_caps [10];
    int unsigned phase_pub [10];
    phase_caps = '{4'd8, 4'd15, 4'd3, 4'd0, 4'd9, 4'd5, 4'd1, 4'd8, 4'd2, 4'd4};
    phase_pub = '{45, 70, 60, 50, 40, 55, 65, 50, 75, 45};
    foreach (payload_mem[i]) begin
      payload_mem[i] = '0;
      flag_mem[i] = '0;
      entry_written[i] = 1'b0;
    end
    foreach (event_ctr[i]) event_ctr[i] = '0;
    wr_pos = '0;
    rd_pos = '0;
    cap_log2 = CAP_LOG2_RST;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_op(make_op(OP_DRAIN, '0, '0, 7'd5, '0, '0));
    queue_op(make_op(OP_SNAPSHOT, '0, '0, 7'd10, '0, '0));
    queue_op(make_op(OP_SNAPSHOT, '0, '0, 7'd10, 64'd1, '0));
    queue_op(make_op(OP_PUBLISH, '1, '1, '0, '0, '0));
    queue_op(make_op(OP_PUBLISH, '0, '0, '0, '0, '0));
    for (int b = 0; b < FLAG_W; b++)
      queue_op(make_op(OP_PUBLISH, FLAG_W'(1 << b), {$urandom, $urandom}, '0, '0, '0));
    queue_op(make_op(OP_SNAPSHOT, '0, '0, '1, '0, '0));
    queue_op(make_op(OP_SNAPSHOT, '0, '0, 7'd3, '1, '0));
    queue_op(make_op(OP_DRAIN, '0, '0, '0, '0, '0));
    queue_op(make_op(OP_DRAIN, '0, '0, 7'd3, '0, '0));
    queue_op(make_op(OP_DRAIN, '0, '0, '1, '0, '0));
    for (int s = 0; s < NUM_CNT; s++)
      queue_op(make_op(OP_STAT, '0, '0, '0, '0, SEL_W'(s)));

    write_cap('0);
    queue_op(make_op(OP_PUBLISH, 4'h5, {$urandom, $urandom}, '0, '0, '0));
    queue_op(make_op(OP_PUBLISH, 4'hA, {$urandom, $urandom}, '0, '0, '0));
    queue_op(make_op(OP_SNAPSHOT, '0, '0, 7'd4, wr_pos - 2, '0));
    queue_op(make_op(OP_STAT, '0, '0, '0, '0, SEL_W'(CNT_DROPPED)));
    queue_op(make_op(OP_DRAIN, '0, '0, 7'd64, '0, '0));

    foreach (phase_caps[p]) begin
      write_cap(phase_caps[p]);
      if (p == 0) begin
        // The receiver holds off while a long run of publish beats is offered.
        hold_arm <= 1'b1;
        repeat (FILL_ITEMS) queue_op(make_op(OP_PUBLISH, FLAG_W'($urandom),
                                             {$urandom, $urandom}, CNT_W'($urandom),
                                             {$urandom, $urandom}, SEL_W'($urandom)));
      end
      repeat (PHASE_ITEMS) queue_op(random_op(phase_pub[p]));
      while (wr_pos != rd_pos)
        queue_op(make_op(OP_DRAIN, FLAG_W'($urandom), {$urandom, $urandom}, 7'd64, '0,
                         SEL_W'($urandom)));
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
